// ===== design/jmix_pkg.sv =====
// ----------------------------------------------------------------------------
// jmix_pkg
// Shared types, queue sizing and the three-line mix step used by the word
// hash front end, queue and back end.
// ----------------------------------------------------------------------------
package jmix_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] MIX_STEP_LAST = 2'd2;

    // Operation the back end applies for one queued word.
    typedef enum logic [2:0] {
        OP_LOAD_A,
        OP_LOAD_B,
        OP_MIX_A,
        OP_SKIP,
        OP_ADD_B,
        OP_ADD_C
    } t_op;

    // Position of the next word within the message.
    typedef enum logic [2:0] {
        PH_A,
        PH_B,
        PH_G0,
        PH_G1,
        PH_G2
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GMIX,
        S_LEN,
        S_FMIX
    } t_bstate;

    typedef struct packed {
        t_op         op;
        logic [31:0] word;
        logic        last;
        logic [31:0] len;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_abc;

    // One third of the nine-line mix: each of a, b and c is updated once.
    function automatic t_abc mix_step(t_abc s, logic [1:0] step);
        logic [4:0] sa;
        logic [4:0] sb;
        logic [4:0] sc;
        t_abc       r;
        case (step)
            2'd0: begin
                sa = 5'd13; sb = 5'd8;  sc = 5'd13;
            end
            2'd1: begin
                sa = 5'd12; sb = 5'd16; sc = 5'd5;
            end
            default: begin
                sa = 5'd3;  sb = 5'd10; sc = 5'd15;
            end
        endcase
        r.a = s.a - s.b - s.c;
        r.a = r.a ^ (s.c >> sa);
        r.b = s.b - s.c - r.a;
        r.b = r.b ^ (r.a << sb);
        r.c = s.c - r.a - r.b;
        r.c = r.c ^ (r.b >> sc);
        return r;
    endfunction

endpackage

// ===== design/jmix_if.sv =====
// ----------------------------------------------------------------------------
// jmix_in_if / jmix_out_if
// Valid/ready channels for message words and for hash results.
// ----------------------------------------------------------------------------
interface jmix_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;

    modport source(output valid, output data_word, output byte_count, output last,
                   input ready);
    modport sink(input valid, input data_word, input byte_count, input last,
                 output ready);
endinterface

interface jmix_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source(output valid, output hash_value, input ready);
    modport sink(input valid, input hash_value, output ready);
endinterface

// ===== design/jmix_front.sv =====
// ----------------------------------------------------------------------------
// jmix_front
// Accepts message words, masks partial words, tracks the word position and
// running length, and turns each word into one queued operation.
// ----------------------------------------------------------------------------
module jmix_front
    import jmix_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    jmix_in_if.sink i_in,
    input  t_q_stat i_stat,
    output logic    o_push,
    output t_entry  o_entry
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_bytes, n_bytes;
    logic [2:0]  w_cnt;
    logic [31:0] w_word;
    logic [31:0] w_len;
    logic        w_acc;

    assign i_in.ready = !i_stat.full;
    assign w_acc      = i_in.valid && !i_stat.full;
    assign o_push     = w_acc;

    assign w_cnt = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;
    assign w_len = r_bytes + {29'd0, w_cnt};

    always_comb begin
        case (w_cnt)
            3'd0:    w_word = 32'd0;
            3'd1:    w_word = {24'd0, i_in.data_word[7:0]};
            3'd2:    w_word = {16'd0, i_in.data_word[15:0]};
            3'd3:    w_word = {8'd0, i_in.data_word[23:0]};
            default: w_word = i_in.data_word;
        endcase
    end

    // Next word position and length.
    always_comb begin
        n_phase = r_phase;
        n_bytes = r_bytes;
        if (w_acc) begin
            n_bytes = w_len;
            case (r_phase)
                PH_A:    n_phase = PH_B;
                PH_B:    n_phase = PH_G0;
                PH_G0:   n_phase = PH_G1;
                PH_G1:   n_phase = PH_G2;
                default: n_phase = PH_G0;
            endcase
            if (i_in.last) begin
                n_phase = PH_A;
                n_bytes = 32'd0;
            end
        end
    end

    // Classify the word.
    always_comb begin
        o_entry.word = w_word;
        o_entry.last = i_in.last;
        o_entry.len  = w_len;
        case (r_phase)
            PH_A:    o_entry.op = OP_LOAD_A;
            PH_B:    o_entry.op = OP_LOAD_B;
            PH_G0:   o_entry.op = (w_cnt != 3'd0) ? OP_MIX_A : OP_SKIP;
            PH_G1:   o_entry.op = OP_ADD_B;
            default: o_entry.op = OP_ADD_C;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_A;
            r_bytes <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_bytes <= n_bytes;
        end
    end

endmodule

// ===== design/jmix_fifo.sv =====
// ----------------------------------------------------------------------------
// jmix_fifo
// Short register queue of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module jmix_fifo
    import jmix_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/jmix_back.sv =====
// ----------------------------------------------------------------------------
// jmix_back
// Holds the a/b/c accumulators, runs the mix three lines per cycle, holding
// the last step while the output stalls, and registers the hash for o_out.
// ----------------------------------------------------------------------------
module jmix_back
    import jmix_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_entry       i_head,
    input  t_q_stat      i_stat,
    output logic         o_pop,
    jmix_out_if.source   o_out
);

    t_bstate     r_state, n_state;
    logic [1:0]  r_step, n_step;
    t_abc        r_acc, n_acc;
    t_entry      r_cur, n_cur;
    logic        r_oval, n_oval;
    logic [31:0] r_hash, n_hash;
    t_abc        w_mix;
    logic        w_slot;

    assign w_mix  = mix_step(r_acc, r_step);
    assign w_slot = !r_oval || o_out.ready;
    assign o_pop  = (r_state == S_IDLE) && !i_stat.empty;

    assign o_out.valid      = r_oval;
    assign o_out.hash_value = r_hash;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    if (i_head.op == OP_MIX_A) begin
                        n_state = S_GMIX;
                    end else if (i_head.last) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_GMIX: begin
                if (r_step == MIX_STEP_LAST) begin
                    n_state = r_cur.last ? S_LEN : S_IDLE;
                end
            end
            S_LEN:   n_state = S_FMIX;
            S_FMIX: begin
                if (r_step == MIX_STEP_LAST && w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb begin
        n_step = r_step;
        n_acc  = r_acc;
        n_cur  = r_cur;
        n_oval = r_oval && !o_out.ready;
        n_hash = r_hash;
        case (r_state)
            S_IDLE: begin
                n_step = 2'd0;
                if (!i_stat.empty) begin
                    n_cur = i_head;
                    case (i_head.op)
                        OP_LOAD_A: n_acc.a = i_head.word;
                        OP_LOAD_B: n_acc.b = i_head.word;
                        OP_ADD_B:  n_acc.b = r_acc.b + i_head.word;
                        OP_ADD_C:  n_acc.c = r_acc.c + i_head.word;
                        default:   n_acc   = r_acc;
                    endcase
                end
            end
            S_GMIX: begin
                n_acc = w_mix;
                if (r_step == MIX_STEP_LAST) begin
                    n_acc.a = w_mix.a + r_cur.word;
                    n_step  = 2'd0;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_LEN: begin
                n_acc.c = r_acc.c + r_cur.len;
                n_step  = 2'd0;
            end
            S_FMIX: begin
                if (r_step != MIX_STEP_LAST) begin
                    n_acc  = w_mix;
                    n_step = r_step + 2'd1;
                end else if (w_slot) begin
                    n_hash = w_mix.c;
                    n_oval = 1'b1;
                    n_acc  = '0;
                    n_step = 2'd0;
                end
            end
            default: n_step = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_hash <= n_hash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_acc   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_acc   <= n_acc;
            r_oval  <= n_oval;
        end
    end

endmodule

// ===== design/jenkins_mix_word_hash.sv =====
// ----------------------------------------------------------------------------
// jenkins_mix_word_hash
// Word-stream hash built on the nine-line lookup2 mix: a front end decodes
// words, a four-entry queue decouples it from the accumulator back end.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | handshake
//  i_in    | in  | data_word[31:0] byte_count[2:0] last | valid/ready
//  o_out   | out | hash_value[31:0]                 | valid/ready
//
// The front end takes one word per cycle while the queue has room.
// The back end pops queued words while idle; a group start first runs the
// mix and then adds the word into a, and the last word is followed by the
// length add and the final mix.
// Synchronous active-low reset clears the queue, word position, length and
// accumulators. A stalled output holds the final mix until the slot frees.
module jenkins_mix_word_hash
    import jmix_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    jmix_in_if.sink    i_in,
    jmix_out_if.source o_out
);

    t_q_stat w_stat;
    t_entry  w_entry;
    t_entry  w_head;
    logic    w_push;
    logic    w_pop;

    jmix_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (w_stat),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    jmix_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_stat)
    );

    jmix_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_stat  (w_stat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // The queue is never reported both full and empty.
    a_stat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stat.full && w_stat.empty))
        else $error("queue reports full and empty");

    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_stat.full)
        else $error("push into full queue");

    // A new result comes out of the final mix, never from a queue pop.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> !$past(w_pop))
        else $error("result raised in a cycle that popped the queue");

endmodule
